@@ rtl/core/tjs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the timed job scheduler.
// No dependencies; imported by timed_job_scheduler_top.
package tjs_pkg;

   // default number of job slots
   localparam int DEFAULT_MAX_JOBS = 16;

   // due margin after reset, and the saturation value of the ticks-ahead count
   localparam logic [15:0] DUE_MARGIN_RESET = 16'd5;
   localparam logic [15:0] TICKS_SAT        = 16'hFFFF;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      ACT_RUN      = 2'd0,
      ACT_SCHEDULE = 2'd1,
      ACT_CLEAR    = 2'd2,
      ACT_POLL     = 2'd3
   } tjs_action_type;

   // which queue holds a slot
   typedef enum logic [1:0] {
      MEMB_NONE  = 2'd0,
      MEMB_RUN   = 2'd1,
      MEMB_TIMED = 2'd2
   } tjs_memb_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POLL_RD,
      ST_POLL_EV,
      ST_CLR_CHK,
      ST_UNL_WALK,
      ST_AFTER_CLR,
      ST_RUN_LINK,
      ST_INS_WALK,
      ST_INS_FIN1,
      ST_INS_FIN2,
      ST_DONE
   } tjs_state_type;

endpackage

@@ rtl/core/timed_job_scheduler_top.sv @@
`timescale 1ns / 1ps
// Timed job scheduler: run FIFO and deadline-sorted timed queue over shared slots.
// Depends on tjs_pkg and tjs_ram (link, deadline and handler memories).
//
//  channel | direction | beat contents
//  --------+-----------+---------------------------------------------------------
//  csr     | in        | csr_wdata = due_margin
//  req     | in        | tuser = action; tdata = job_id, deadline, handler, now
//  rsp     | out       | tuser = dispatched; tdata = dispatched_job, handler
//
// One request is worked at a time; every request yields one response beat.
// The walks step one linked entry per cycle through the single read port of the
// link and deadline memories.
// A finished response waits in the output register while the next request is
// taken; the sequencer holds in its final state only if that register is full.
// Reset empties both queues and sets due_margin to 5; slot memories need no clear.
module timed_job_scheduler_top #(
   parameter int MAX_JOBS = tjs_pkg::DEFAULT_MAX_JOBS
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata,   // due_margin
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // job_id[3:0], deadline[35:4], handler[43:36],
                                    // now[75:44], zero[79:76]
   input  logic [1:0]  req_tuser,   // action[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // dispatched_job[3:0], dispatched_handler[11:4],
                                    // zero[15:12]
   output logic [0:0]  rsp_tuser    // dispatched[0]
);

   import tjs_pkg::*;

   localparam int SW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int LW = $clog2(MAX_JOBS + 1);
   localparam logic [LW-1:0] NIL = LW'(MAX_JOBS);

   // registers
   tjs_state_type  state_ff, state_in;
   tjs_action_type act_ff, act_in;
   logic [3:0]     job_ff, job_in;
   logic [31:0]    dl_ff, dl_in;
   logic [7:0]     hd_ff, hd_in;
   logic [31:0]    now_ff, now_in;
   logic [15:0]    margin_ff;
   logic [LW-1:0]  run_head_ff, run_head_in;
   logic [LW-1:0]  run_tail_ff, run_tail_in;
   logic [LW-1:0]  timed_head_ff, timed_head_in;
   logic [LW-1:0]  cur_ff, cur_in;
   logic [LW-1:0]  prev_ff, prev_in;
   logic [LW-1:0]  cnt_ff, cnt_in;
   logic           qrun_ff, qrun_in;
   logic           res_disp_ff, res_disp_in;
   logic [3:0]     res_job_ff, res_job_in;
   logic [7:0]     res_hd_ff, res_hd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_disp_ff, rsp_disp_in;
   logic [3:0]     rsp_job_ff, rsp_job_in;
   logic [7:0]     rsp_hd_ff, rsp_hd_in;
   tjs_memb_type   memb_ff [MAX_JOBS];

   // membership write port
   logic           memb_we;
   logic [SW-1:0]  memb_wa;
   tjs_memb_type   memb_wd;

   // memory ports
   logic [SW-1:0]  rd_addr;
   logic           link_we;
   logic [SW-1:0]  link_wa;
   logic [LW-1:0]  link_wd;
   logic           dl_we;
   logic           hd_we;
   logic [LW-1:0]  link_q;
   logic [31:0]    dl_q;
   logic [7:0]     hd_q;

   // decoded conditions
   logic           req_acc;
   logic [SW-1:0]  job_idx;
   logic [LW-1:0]  job_l;
   logic           run_ok;
   logic           timed_ok;
   logic [31:0]    poll_diff;
   logic [15:0]    ticks;
   logic           due;
   logic [31:0]    ins_diff;
   logic           later;
   logic           walk_end;
   logic           unl_hit;
   logic           ins_stop;

   // slot memories
   tjs_ram #(.WIDTH(LW), .DEPTH(MAX_JOBS)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_wa),
      .wdata (link_wd),
      .raddr (rd_addr),
      .rdata (link_q)
   );

   tjs_ram #(.WIDTH(32), .DEPTH(MAX_JOBS)) u_deadline_ram (
      .clock (clock),
      .we    (dl_we),
      .waddr (job_idx),
      .wdata (dl_ff),
      .raddr (rd_addr),
      .rdata (dl_q)
   );

   tjs_ram #(.WIDTH(8), .DEPTH(MAX_JOBS)) u_handler_ram (
      .clock (clock),
      .we    (hd_we),
      .waddr (job_idx),
      .wdata (hd_ff),
      .raddr (rd_addr),
      .rdata (hd_q)
   );

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // slot decode
   assign job_idx = SW'(job_ff);
   assign job_l   = LW'(job_ff);

   // queue heads
   assign run_ok   = (run_head_ff < NIL);
   assign timed_ok = (timed_head_ff < NIL);

   // due test: ticks ahead, past deadlines count as zero, far ones saturate
   assign poll_diff = dl_q - now_ff;
   always_comb begin
      if (poll_diff == 32'd0 || poll_diff[31]) begin
         ticks = 16'd0;
      end else if (poll_diff[31:16] != 16'd0) begin
         ticks = TICKS_SAT;
      end else begin
         ticks = poll_diff[15:0];
      end
   end
   assign due = (ticks < margin_ff);

   // insertion order: stop at the first entry whose deadline is strictly later
   assign ins_diff = dl_q - dl_ff;
   assign later    = (ins_diff != 32'd0) && !ins_diff[31];

   // walk termination
   assign walk_end = (cnt_ff == NIL) || (cur_ff >= NIL);
   assign unl_hit  = (cur_ff == job_l);
   assign ins_stop = walk_end || later;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (tjs_action_type'(req_tuser) == ACT_POLL) begin
                  state_in = ST_POLL_RD;
               end else if (32'(req_tdata[3:0]) < MAX_JOBS) begin
                  state_in = ST_CLR_CHK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_POLL_RD:   state_in = ST_POLL_EV;
         ST_POLL_EV:   state_in = ST_DONE;
         ST_CLR_CHK: begin
            if (memb_ff[job_idx] == MEMB_NONE) begin
               state_in = ST_AFTER_CLR;
            end else begin
               state_in = ST_UNL_WALK;
            end
         end
         ST_UNL_WALK: begin
            if (walk_end || unl_hit) begin
               state_in = ST_AFTER_CLR;
            end
         end
         ST_AFTER_CLR: begin
            case (act_ff)
               ACT_RUN:      state_in = ST_RUN_LINK;
               ACT_SCHEDULE: state_in = ST_INS_WALK;
               default:      state_in = ST_DONE;
            endcase
         end
         ST_RUN_LINK:  state_in = ST_DONE;
         ST_INS_WALK: begin
            if (ins_stop) begin
               state_in = ST_INS_FIN1;
            end
         end
         ST_INS_FIN1:  state_in = ST_INS_FIN2;
         ST_INS_FIN2:  state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      act_in        = act_ff;
      job_in        = job_ff;
      dl_in         = dl_ff;
      hd_in         = hd_ff;
      now_in        = now_ff;
      run_head_in   = run_head_ff;
      run_tail_in   = run_tail_ff;
      timed_head_in = timed_head_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      cnt_in        = cnt_ff;
      qrun_in       = qrun_ff;
      res_disp_in   = res_disp_ff;
      res_job_in    = res_job_ff;
      res_hd_in     = res_hd_ff;
      rsp_disp_in   = rsp_disp_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_hd_in     = rsp_hd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      memb_we       = 1'b0;
      memb_wa       = job_idx;
      memb_wd       = MEMB_NONE;
      rd_addr       = cur_ff[SW-1:0];
      link_we       = 1'b0;
      link_wa       = job_idx;
      link_wd       = NIL;
      dl_we         = 1'b0;
      hd_we         = 1'b0;

      case (state_ff)
         // capture the request beat, start with an empty result
         ST_IDLE: begin
            if (req_acc) begin
               act_in      = tjs_action_type'(req_tuser);
               job_in      = req_tdata[3:0];
               dl_in       = req_tdata[35:4];
               hd_in       = req_tdata[43:36];
               now_in      = req_tdata[75:44];
               res_disp_in = 1'b0;
               res_job_in  = 4'd0;
               res_hd_in   = 8'd0;
            end
         end
         // read the head that a poll would take
         ST_POLL_RD: begin
            rd_addr = run_ok ? run_head_ff[SW-1:0] : timed_head_ff[SW-1:0];
         end
         // pop the run head, else the timed head when due
         ST_POLL_EV: begin
            if (run_ok) begin
               res_disp_in = 1'b1;
               res_job_in  = 4'(run_head_ff);
               res_hd_in   = hd_q;
               memb_we     = 1'b1;
               memb_wa     = run_head_ff[SW-1:0];
               if (link_q >= NIL) begin
                  run_head_in = NIL;
                  run_tail_in = NIL;
               end else begin
                  run_head_in = link_q;
               end
            end else if (timed_ok && due) begin
               res_disp_in   = 1'b1;
               res_job_in    = 4'(timed_head_ff);
               res_hd_in     = hd_q;
               memb_we       = 1'b1;
               memb_wa       = timed_head_ff[SW-1:0];
               timed_head_in = (link_q >= NIL) ? NIL : link_q;
            end
         end
         // pick the queue to unlink from, read its head
         ST_CLR_CHK: begin
            prev_in = NIL;
            cnt_in  = '0;
            memb_we = 1'b1;
            case (memb_ff[job_idx])
               MEMB_TIMED: begin
                  qrun_in = 1'b0;
                  cur_in  = timed_head_ff;
                  rd_addr = timed_head_ff[SW-1:0];
               end
               MEMB_RUN: begin
                  qrun_in = 1'b1;
                  cur_in  = run_head_ff;
                  rd_addr = run_head_ff[SW-1:0];
               end
               default: begin
                  qrun_in = qrun_ff;
               end
            endcase
         end
         // walk to the job and splice it out
         ST_UNL_WALK: begin
            if (!walk_end) begin
               if (unl_hit) begin
                  if (prev_ff >= NIL) begin
                     if (qrun_ff) begin
                        run_head_in = link_q;
                     end else begin
                        timed_head_in = link_q;
                     end
                  end else begin
                     link_we = 1'b1;
                     link_wa = prev_ff[SW-1:0];
                     link_wd = link_q;
                  end
                  if (qrun_ff && run_tail_ff == job_l) begin
                     run_tail_in = prev_ff;
                  end
               end else begin
                  prev_in = cur_ff;
                  cur_in  = link_q;
                  rd_addr = link_q[SW-1:0];
                  cnt_in  = cnt_ff + 1'b1;
               end
            end
         end
         // store the slot payload for run and schedule; for a schedule, start the insertion walk
         ST_AFTER_CLR: begin
            case (act_ff)
               ACT_RUN: begin
                  hd_we   = 1'b1;
                  link_we = 1'b1;
                  link_wd = NIL;
               end
               ACT_SCHEDULE: begin
                  dl_we   = 1'b1;
                  hd_we   = 1'b1;
                  rd_addr = timed_head_ff[SW-1:0];
                  cur_in  = timed_head_ff;
                  prev_in = NIL;
                  cnt_in  = '0;
               end
               default: begin
                  hd_we = 1'b0;
               end
            endcase
         end
         // append to the run queue
         ST_RUN_LINK: begin
            if (run_head_ff >= NIL || run_tail_ff >= NIL) begin
               run_head_in = job_l;
            end else begin
               link_we = 1'b1;
               link_wa = run_tail_ff[SW-1:0];
               link_wd = job_l;
            end
            run_tail_in = job_l;
            memb_we     = 1'b1;
            memb_wd     = MEMB_RUN;
         end
         // advance past entries due no later than the new deadline
         ST_INS_WALK: begin
            if (!ins_stop) begin
               prev_in = cur_ff;
               cur_in  = link_q;
               rd_addr = link_q[SW-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         // point the job at its successor
         ST_INS_FIN1: begin
            link_we = 1'b1;
            link_wd = (cur_ff >= NIL) ? NIL : cur_ff;
         end
         // hook the job behind its predecessor
         ST_INS_FIN2: begin
            if (prev_ff >= NIL) begin
               timed_head_in = job_l;
            end else begin
               link_we = 1'b1;
               link_wa = prev_ff[SW-1:0];
               link_wd = job_l;
            end
            memb_we = 1'b1;
            memb_wd = MEMB_TIMED;
         end
         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_disp_in  = res_disp_ff;
               rsp_job_in   = res_job_ff;
               rsp_hd_in    = res_hd_ff;
            end
         end
         default: begin
            rd_addr = cur_ff[SW-1:0];
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_head_ff   <= NIL;
         run_tail_ff   <= NIL;
         timed_head_ff <= NIL;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         margin_ff     <= DUE_MARGIN_RESET;
      end else begin
         state_ff      <= state_in;
         run_head_ff   <= run_head_in;
         run_tail_ff   <= run_tail_in;
         timed_head_ff <= timed_head_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            margin_ff <= csr_wdata;
         end
      end
   end

   // slot membership flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_JOBS; i++) begin
            memb_ff[i] <= MEMB_NONE;
         end
      end else if (memb_we) begin
         memb_ff[memb_wa] <= memb_wd;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      job_ff      <= job_in;
      dl_ff       <= dl_in;
      hd_ff       <= hd_in;
      now_ff      <= now_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      qrun_ff     <= qrun_in;
      res_disp_ff <= res_disp_in;
      res_job_ff  <= res_job_in;
      res_hd_ff   <= res_hd_in;
      rsp_disp_ff <= rsp_disp_in;
      rsp_job_ff  <= rsp_job_in;
      rsp_hd_ff   <= rsp_hd_in;
   end

   // response port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_hd_ff, rsp_job_ff};
   assign rsp_tuser  = rsp_disp_ff;

   // a taken request closes the request side until its work is done
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request accepted while a request is in progress");

   // walk counter never passes the slot count
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NIL)
      else $error("queue walk ran past the slot count");

   // run queue head and tail are empty together
   assert property (@(posedge clock) disable iff (reset)
      (run_head_ff >= NIL) == (run_tail_ff >= NIL))
      else $error("run queue head and tail disagree on emptiness");

   // a response without a dispatch carries no job
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_disp_ff) |-> (rsp_job_ff == 4'd0 && rsp_hd_ff == 8'd0))
      else $error("empty response carries job data");

endmodule

@@ rtl/core/tjs_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies on other project files.
module tjs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write when enabled
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read every cycle, data registered and valid in the next cycle
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule
